FILE: design/qvr_pkg.sv
`default_nettype none
package qvr_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int CORDIC_N      = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

    localparam int XW = 33;   // CORDIC x/y, Q.30 plus headroom
    localparam int ZW = 29;   // angle accumulator, 2^-20 degree units
    localparam int SW = 5;    // stage index width

    localparam logic signed [XW-1:0] CORDIC_INV_GAIN = 33'sd652032874;
    localparam logic signed [ZW-1:0] DEG90  = 29'sd94371840;
    localparam logic signed [ZW-1:0] DEG180 = 29'sd188743680;

    typedef logic signed [15:0] comp_t;

    typedef struct packed {
        logic                 valid;
        logic                 flip;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        comp_t                axis_x;
        comp_t                axis_y;
        comp_t                axis_z;
        comp_t                vec_x;
        comp_t                vec_y;
        comp_t                vec_z;
    } cordic_word_t;

    function automatic logic signed [ZW-1:0] atan_lut(input logic [SW-1:0] idx);
        logic signed [ZW-1:0] r;
        case (idx)
            5'd0:    r = 29'sd47185920;
            5'd1:    r = 29'sd27855475;
            5'd2:    r = 29'sd14718068;
            5'd3:    r = 29'sd7471121;
            5'd4:    r = 29'sd3750058;
            5'd5:    r = 29'sd1876857;
            5'd6:    r = 29'sd938658;
            5'd7:    r = 29'sd469357;
            5'd8:    r = 29'sd234682;
            5'd9:    r = 29'sd117342;
            5'd10:   r = 29'sd58671;
            5'd11:   r = 29'sd29335;
            5'd12:   r = 29'sd14668;
            5'd13:   r = 29'sd7334;
            5'd14:   r = 29'sd3667;
            5'd15:   r = 29'sd1833;
            5'd16:   r = 29'sd917;
            5'd17:   r = 29'sd458;
            5'd18:   r = 29'sd229;
            5'd19:   r = 29'sd115;
            5'd20:   r = 29'sd57;
            5'd21:   r = 29'sd29;
            5'd22:   r = 29'sd14;
            5'd23:   r = 29'sd7;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: design/qvr_cordic_cell.sv
`default_nettype none
module qvr_cordic_cell (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       advance,
    input  wire logic [qvr_pkg::SW-1:0]     stage,
    input  wire qvr_pkg::cordic_word_t      in_word,
    output qvr_pkg::cordic_word_t           out_word
);
    import qvr_pkg::*;

    logic                 valid_reg;
    cordic_word_t         word_reg;
    cordic_word_t         word_next;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] ang;

    always_comb
    begin
        dx        = in_word.y >>> stage;
        dy        = in_word.x >>> stage;
        ang       = atan_lut(stage);
        word_next = in_word;
        if (!in_word.z[ZW-1])
        begin
            word_next.x = in_word.x - dx;
            word_next.y = in_word.y + dy;
            word_next.z = in_word.z - ang;
        end
        else
        begin
            word_next.x = in_word.x + dx;
            word_next.y = in_word.y - dy;
            word_next.z = in_word.z + ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_word.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            word_reg <= word_next;
    end

    always_comb
    begin
        out_word       = word_reg;
        out_word.valid = valid_reg;
    end

endmodule
`default_nettype wire

FILE: design/qvr_rotate.sv
`default_nettype none
module qvr_rotate (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   advance,
    input  wire qvr_pkg::cordic_word_t  in_word,
    output logic                        out_valid,
    output qvr_pkg::comp_t              rot_x,
    output qvr_pkg::comp_t              rot_y,
    output qvr_pkg::comp_t              rot_z,
    output logic                        clipped
);
    import qvr_pkg::*;

    // stage Q: quaternion, Q.24
    logic                 q_valid_reg;
    logic signed [25:0]   qw_reg;
    logic signed [26:0]   qx_reg, qy_reg, qz_reg;
    comp_t                vx_reg, vy_reg, vz_reg;
    logic signed [XW-1:0] c30, s30;
    logic signed [48:0]   ax_s, ay_s, az_s;
    logic signed [XW-1:0] cw_r;

    always_comb
    begin
        c30  = in_word.flip ? -in_word.x : in_word.x;
        s30  = in_word.flip ? -in_word.y : in_word.y;
        ax_s = 49'(in_word.axis_x) * 49'(s30) + 49'sd524288;
        ay_s = 49'(in_word.axis_y) * 49'(s30) + 49'sd524288;
        az_s = 49'(in_word.axis_z) * 49'(s30) + 49'sd524288;
        cw_r = c30 + 33'sd32;
    end

    // stage P: q * v, Q.24
    logic                 p_valid_reg;
    logic signed [29:0]   pw_reg, px_reg, py_reg, pz_reg;
    logic signed [25:0]   qw2_reg;
    logic signed [26:0]   qx2_reg, qy2_reg, qz2_reg;
    logic signed [44:0]   pw_s, px_s, py_s, pz_s;

    always_comb
    begin
        pw_s = -(45'(qx_reg) * 45'(vx_reg)) - (45'(qy_reg) * 45'(vy_reg))
               - (45'(qz_reg) * 45'(vz_reg)) + 45'sd8192;
        px_s = (45'(qw_reg) * 45'(vx_reg)) + (45'(qy_reg) * 45'(vz_reg))
               - (45'(qz_reg) * 45'(vy_reg)) + 45'sd8192;
        py_s = (45'(qw_reg) * 45'(vy_reg)) + (45'(qz_reg) * 45'(vx_reg))
               - (45'(qx_reg) * 45'(vz_reg)) + 45'sd8192;
        pz_s = (45'(qw_reg) * 45'(vz_reg)) + (45'(qx_reg) * 45'(vy_reg))
               - (45'(qy_reg) * 45'(vx_reg)) + 45'sd8192;
    end

    // stage R: p * conj(q), Q.48
    logic                 r_valid_reg;
    logic signed [59:0]   rx_reg, ry_reg, rz_reg;
    logic signed [59:0]   rx_s, ry_s, rz_s;

    always_comb
    begin
        rx_s = (60'(px_reg) * 60'(qw2_reg)) - (60'(pw_reg) * 60'(qx2_reg))
               - (60'(py_reg) * 60'(qz2_reg)) + (60'(pz_reg) * 60'(qy2_reg));
        ry_s = (60'(py_reg) * 60'(qw2_reg)) - (60'(pw_reg) * 60'(qy2_reg))
               - (60'(pz_reg) * 60'(qx2_reg)) + (60'(px_reg) * 60'(qz2_reg));
        rz_s = (60'(pz_reg) * 60'(qw2_reg)) - (60'(pw_reg) * 60'(qz2_reg))
               - (60'(px_reg) * 60'(qy2_reg)) + (60'(py_reg) * 60'(qx2_reg));
    end

    // output stage: round to Q.14 and saturate
    logic                 o_valid_reg;
    comp_t                ox_reg, oy_reg, oz_reg;
    logic                 clip_reg;
    logic signed [59:0]   rx_h, ry_h, rz_h;
    logic signed [25:0]   rx_t, ry_t, rz_t;
    logic                 cx, cy, cz;
    comp_t                sx, sy, sz;

    always_comb
    begin
        rx_h = (rx_reg + (60'sd1 <<< 33)) >>> 34;
        ry_h = (ry_reg + (60'sd1 <<< 33)) >>> 34;
        rz_h = (rz_reg + (60'sd1 <<< 33)) >>> 34;
        rx_t = rx_h[25:0];
        ry_t = ry_h[25:0];
        rz_t = rz_h[25:0];
        cx   = (rx_t > 26'sd32767) || (rx_t < -26'sd32768);
        cy   = (ry_t > 26'sd32767) || (ry_t < -26'sd32768);
        cz   = (rz_t > 26'sd32767) || (rz_t < -26'sd32768);
        sx   = cx ? (rx_t[25] ? comp_t'(16'h8000) : comp_t'(16'h7fff)) : rx_t[15:0];
        sy   = cy ? (ry_t[25] ? comp_t'(16'h8000) : comp_t'(16'h7fff)) : ry_t[15:0];
        sz   = cz ? (rz_t[25] ? comp_t'(16'h8000) : comp_t'(16'h7fff)) : rz_t[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            q_valid_reg <= in_word.valid;
            p_valid_reg <= q_valid_reg;
            r_valid_reg <= p_valid_reg;
            o_valid_reg <= r_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            qw_reg  <= cw_r[31:6];
            qx_reg  <= ax_s[46:20];
            qy_reg  <= ay_s[46:20];
            qz_reg  <= az_s[46:20];
            vx_reg  <= in_word.vec_x;
            vy_reg  <= in_word.vec_y;
            vz_reg  <= in_word.vec_z;

            pw_reg  <= pw_s[43:14];
            px_reg  <= px_s[43:14];
            py_reg  <= py_s[43:14];
            pz_reg  <= pz_s[43:14];
            qw2_reg <= qw_reg;
            qx2_reg <= qx_reg;
            qy2_reg <= qy_reg;
            qz2_reg <= qz_reg;

            rx_reg  <= rx_s;
            ry_reg  <= ry_s;
            rz_reg  <= rz_s;

            ox_reg   <= sx;
            oy_reg   <= sy;
            oz_reg   <= sz;
            clip_reg <= cx | cy | cz;
        end
    end

    assign out_valid = o_valid_reg;
    assign rot_x     = ox_reg;
    assign rot_y     = oy_reg;
    assign rot_z     = oz_reg;
    assign clipped   = clip_reg;

    a_clip_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (o_valid_reg && clip_reg) |-> (ox_reg == 16'sh7fff || ox_reg == 16'sh8000 ||
        oy_reg == 16'sh7fff || oy_reg == 16'sh8000 || oz_reg == 16'sh7fff ||
        oz_reg == 16'sh8000))
        else $error("clip flag without a saturated component");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(ox_reg) && $stable(clip_reg) && $stable(o_valid_reg)))
        else $error("output word changed while stalled");

    a_valid_shift: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (o_valid_reg == $past(r_valid_reg) && r_valid_reg == $past(p_valid_reg)))
        else $error("valid lost in quaternion stages");

endmodule
`default_nettype wire

FILE: design/quaternion_vector_rotate_core.sv
`default_nettype none
// Rotates a Q2.14 vector about a Q2.14 axis by an angle in 1/64 degree units, using
// q*v*conj(q) with q built from a pipelined CORDIC sine/cosine of the half angle. The axis
// is not normalized. One word is accepted per clock unless stalled. The CORDIC cell
// registers are followed by quaternion, product, conjugate product and round/saturate
// stages. The whole pipeline stalls while the output word is held by m_tready low.
module quaternion_vector_rotate_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // angle, axis_x, axis_y, axis_z, vec_x, vec_y, vec_z
    input  wire logic [111:0]  s_tdata,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // rot_x, rot_y, rot_z
    output logic [47:0]        m_tdata,
    // clipped
    output logic               m_tuser
);
    import qvr_pkg::*;

    logic                 advance;
    cordic_word_t         head;
    cordic_word_t         chain [0:CORDIC_N];
    logic signed [ZW-1:0] z0;
    comp_t                rx, ry, rz;
    logic                 clip;

    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    // fold half angle into [-90, 90] degrees
    always_comb
    begin
        z0 = {s_tdata[15:0], 13'b0};
        head.valid  = s_tvalid;
        head.flip   = 1'b0;
        head.x      = CORDIC_INV_GAIN;
        head.y      = '0;
        head.z      = z0;
        head.axis_x = s_tdata[31:16];
        head.axis_y = s_tdata[47:32];
        head.axis_z = s_tdata[63:48];
        head.vec_x  = s_tdata[79:64];
        head.vec_y  = s_tdata[95:80];
        head.vec_z  = s_tdata[111:96];
        if (z0 > DEG90)
        begin
            head.z    = z0 - DEG180;
            head.flip = 1'b1;
        end
        else if (z0 < -DEG90)
        begin
            head.z    = z0 + DEG180;
            head.flip = 1'b1;
        end
    end

    assign chain[0] = head;

    genvar gi;
    generate
        for (gi = 0; gi < CORDIC_N; gi++)
        begin : g_cell
            qvr_cordic_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .advance  (advance),
                .stage    (SW'(gi)),
                .in_word  (chain[gi]),
                .out_word (chain[gi+1])
            );
        end
    endgenerate

    qvr_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_word   (chain[CORDIC_N]),
        .out_valid (m_tvalid),
        .rot_x     (rx),
        .rot_y     (ry),
        .rot_z     (rz),
        .clipped   (clip)
    );

    assign m_tdata = {rz, ry, rx};
    assign m_tuser = clip;

endmodule
`default_nettype wire
